// ===== rtl/tbd_pkg.sv =====
// ----------------------------------------------------------------------------
// tbd_pkg
// Shared constants and types for the type bitmap decoder.
// ----------------------------------------------------------------------------
package tbd_pkg;

	localparam int MAX_BLOCK_BYTES = 32;
	localparam int LEFT_W          = 6;
	localparam int POS_W           = 5;
	localparam int QUEUE_DEPTH     = 4;
	localparam int QPTR_W          = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W          = $clog2(QUEUE_DEPTH + 1);

	// parser phase codes
	localparam logic [1:0] PH_WINDOW = 2'd0;
	localparam logic [1:0] PH_LENGTH = 2'd1;
	localparam logic [1:0] PH_BITMAP = 2'd2;
	localparam logic [1:0] PH_ERROR  = 2'd3;

	// one classified request from the parser to the expander
	typedef struct packed {
		logic [7:0]  mask;     // bitmap bits still to emit, msb first
		logic [12:0] base_hi;  // window and byte position, type code bits 15:3
		logic        done;     // close the field after the bits
		logic        bad;      // field status on the closing result
	} tbd_entry_t;

endpackage

// ===== rtl/tbd_front.sv =====
// ----------------------------------------------------------------------------
// tbd_front
// Window block parser: tracks phase, window and byte position per input byte.
// ----------------------------------------------------------------------------
module tbd_front
	import tbd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] data_byte,
	input  logic       last_byte,
	input  logic       q_full,
	output logic       push,
	output tbd_entry_t push_entry
);

	logic [1:0]        phase_q;
	logic [7:0]        win_q;
	logic [LEFT_W-1:0] left_q;
	logic [POS_W-1:0]  pos_q;

	logic              accept;
	logic [1:0]        phase_n;
	logic [7:0]        win_n;
	logic [LEFT_W-1:0] left_n;
	logic [POS_W-1:0]  pos_n;
	logic              bad;
	logic              is_bitmap;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;

	always_comb begin
		phase_n   = phase_q;
		win_n     = win_q;
		left_n    = left_q;
		pos_n     = pos_q;
		bad       = 1'b1;
		is_bitmap = 1'b0;
		unique case (phase_q)
			PH_WINDOW: begin
				win_n   = data_byte;
				phase_n = PH_LENGTH;
			end
			PH_LENGTH: begin
				if (data_byte == 8'd0 || data_byte > 8'(MAX_BLOCK_BYTES)) begin
					phase_n = PH_ERROR;
				end else begin
					left_n  = data_byte[LEFT_W-1:0];
					pos_n   = '0;
					phase_n = PH_BITMAP;
				end
			end
			PH_BITMAP: begin
				is_bitmap = 1'b1;
				left_n    = left_q - LEFT_W'(1);
				pos_n     = pos_q + POS_W'(1);
				if (left_n == '0) begin
					phase_n = PH_WINDOW;
					bad     = 1'b0;
				end
			end
			PH_ERROR: begin
				bad = 1'b1;
			end
		endcase
		// closing byte returns the parser to its start state
		if (last_byte) begin
			phase_n = PH_WINDOW;
			win_n   = '0;
			left_n  = '0;
			pos_n   = '0;
		end
	end

	// drop bytes that produce no result
	assign push = accept && ((is_bitmap && data_byte != 8'd0) || last_byte);
	assign push_entry.mask    = is_bitmap ? data_byte : 8'd0;
	assign push_entry.base_hi = {win_q, pos_q};
	assign push_entry.done    = last_byte;
	assign push_entry.bad     = bad;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_WINDOW;
			win_q   <= '0;
			left_q  <= '0;
			pos_q   <= '0;
		end else if (accept) begin
			phase_q <= phase_n;
			win_q   <= win_n;
			left_q  <= left_n;
			pos_q   <= pos_n;
		end
	end

endmodule

// ===== rtl/tbd_queue.sv =====
// ----------------------------------------------------------------------------
// tbd_queue
// Short request queue between parser and expander.
// ----------------------------------------------------------------------------
module tbd_queue
	import tbd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  tbd_entry_t push_entry,
	input  logic       pop,
	output logic       q_valid,
	output logic       q_full,
	output tbd_entry_t q_head
);

	tbd_entry_t        mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign q_valid = count_q != '0;
	assign q_full  = count_q == QCNT_W'(QUEUE_DEPTH);
	assign q_head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

endmodule

// ===== rtl/tbd_back.sv =====
// ----------------------------------------------------------------------------
// tbd_back
// Expander: turns each request into type results, one per cycle while the
// output is not stalled, and closes the field with the done result.
// ----------------------------------------------------------------------------
module tbd_back
	import tbd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_valid,
	input  tbd_entry_t  q_head,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] type_code,
	output logic        done_res,
	output logic        bad_field,
	output logic        last_of_run
);

	logic        busy_q;
	logic [7:0]  mask_q;
	logic [12:0] base_hi_q;
	logic        done_q;
	logic        bad_q;

	logic        out_valid_q;
	logic [15:0] code_q;
	logic        done_out_q;
	logic        bad_out_q;
	logic        last_out_q;

	logic        adv;
	logic        emit;
	logic        finished;
	logic [2:0]  sel;
	logic [7:0]  mask_n;
	logic [15:0] code_n;
	logic        done_n;
	logic        bad_n;

	// first set bit from the msb
	always_comb begin
		sel = 3'd0;
		for (int j = 7; j >= 0; j--) begin
			if (mask_q[7 - j]) begin
				sel = 3'(j);
			end
		end
	end

	always_comb begin
		if (mask_q != 8'd0) begin
			mask_n   = mask_q & ~(8'h80 >> sel);
			code_n   = {base_hi_q, sel};
			done_n   = 1'b0;
			bad_n    = 1'b0;
			finished = (mask_n == 8'd0) && !done_q;
		end else begin
			mask_n   = mask_q;
			code_n   = 16'd0;
			done_n   = 1'b1;
			bad_n    = bad_q;
			finished = 1'b1;
		end
	end

	assign adv  = !out_valid_q || !out_stall;
	assign emit = busy_q && adv;
	assign pop  = q_valid && (!busy_q || (emit && finished));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
			end else if (emit && finished) begin
				busy_q <= 1'b0;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			mask_q    <= q_head.mask;
			base_hi_q <= q_head.base_hi;
			done_q    <= q_head.done;
			bad_q     <= q_head.bad;
		end else if (emit) begin
			mask_q <= mask_n;
		end
		if (emit) begin
			code_q     <= code_n;
			done_out_q <= done_n;
			bad_out_q  <= bad_n;
			last_out_q <= finished;
		end
	end

	assign out_valid   = out_valid_q;
	assign type_code   = code_q;
	assign done_res    = done_out_q;
	assign bad_field   = bad_out_q;
	assign last_of_run = last_out_q;

	// a request with no bits left must be one that closes the field
	a_empty_is_done: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && mask_q == 8'd0) |-> done_q)
		else $error("expander holds an empty request without done");

	// the done result carries no type and always ends the run
	a_done_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && done_out_q) |-> (code_q == 16'd0 && last_out_q))
		else $error("malformed done result");

	// status is reported only on the done result
	a_bad_on_done: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && bad_out_q) |-> done_out_q)
		else $error("bad_field set on a type result");

	// a request is taken only when the expander is free or finishing
	a_pop_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (q_valid && (!busy_q || finished)))
		else $error("queue popped while expander still busy");

endmodule

// ===== rtl/dns_type_bitmap_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// dns_type_bitmap_decoder_unit
// NSEC/NSEC3 type bitmap decoder: bytes in, record type codes out.
// ----------------------------------------------------------------------------
// Each input byte is parsed by the front parser as it is accepted. A bitmap byte
// with set bits, or the final byte of a field, becomes a request in a
// four-entry queue; the expander emits one result per cycle from it while
// the output is not stalled, one per set bit, plus the done result for the
// final byte. Bytes that yield no result (window, length, empty bitmap,
// skipped bytes) never reach the expander. Input is stalled only while the
// queue is full; the expander holds while a result waits in the registered
// output, and an accepted byte passes through the queue and the expander's
// request registers before its first result is registered at the output.
// ----------------------------------------------------------------------------
module dns_type_bitmap_decoder_unit
	import tbd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] type_code,
	output logic        done_res,
	output logic        bad_field,
	output logic        last_of_run
);

	logic       push;
	tbd_entry_t push_entry;
	logic       pop;
	logic       q_valid;
	logic       q_full;
	tbd_entry_t q_head;

	tbd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.data_byte  (data_byte),
		.last_byte  (last_byte),
		.q_full     (q_full),
		.push       (push),
		.push_entry (push_entry)
	);

	tbd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.q_valid    (q_valid),
		.q_full     (q_full),
		.q_head     (q_head)
	);

	tbd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_head      (q_head),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.type_code   (type_code),
		.done_res    (done_res),
		.bad_field   (bad_field),
		.last_of_run (last_of_run)
	);

endmodule
